// File: src/periodic_keepalive_scheduler_macros.svh
// assertion macros for the keepalive scheduler
`ifndef PERIODIC_KEEPALIVE_SCHEDULER_MACROS_SVH
`define PERIODIC_KEEPALIVE_SCHEDULER_MACROS_SVH

// property checked at every clock edge outside reset
`define PKS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition implies another in the next cycle
`define PKS_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// File: src/pks_pkg.sv
// shared types and constants of the keepalive scheduler
package pks_pkg;

	localparam int SLOTS = 8;
	localparam int BUS_COUNT = 4;

	localparam int BUS_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NEXT_CELL = (SLOTS > 1) ? 1 : 0;

	localparam int MASK_W = 4;
	localparam int ID_W = 12;
	localparam int IVL_W = 16;
	localparam int FBUS_W = 3;
	localparam int ST_W = 3;

	localparam logic [ID_W-1:0] ECU_LIMIT = 12'hfff;
	localparam logic [7:0] PCI_SINGLE_LEN2 = 8'h02;
	localparam logic [7:0] SVC_TESTER_PRESENT = 8'h3e;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP = 2'd2;
	localparam logic [1:0] REQ_STOP_ALL = 2'd3;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_BADARG = 3'd1;
	localparam logic [ST_W-1:0] ST_INACTIVE = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd5;
	localparam logic [ST_W-1:0] ST_FULL = 3'd6;

	typedef struct packed {
		logic [BUS_W-1:0] bus;
		logic [ID_W-1:0] id;
		logic [IVL_W-1:0] interval;
		logic [IVL_W-1:0] phase;
	} entry_t;

endpackage

// File: src/pks_cell.sv
// one table slot of the sender ring, loaded from its neighbor on each shift
module pks_cell import pks_pkg::*; (
	input logic clk,
	input logic shift,
	input entry_t din,
	output entry_t dout
);

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= din;
		end
	end

	assign dout = ent_q;

endmodule

// File: src/periodic_keepalive_scheduler.sv
// keepalive scheduler top level: sender ring, request sequencer and output register
// ticks and starts or stops that pass the argument checks are accepted, then rotate the ring
// once in full past its head cell, then issue the final result; stop all and rejected
// arguments go straight from acceptance to the final result
// a held output register stalls the rotation at each further frame and holds the final step
// reset clears the entry count, sequencer and output valid; slots are read below the count only
`include "periodic_keepalive_scheduler_macros.svh"
module periodic_keepalive_scheduler import pks_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [MASK_W-1:0] cfg_wr_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // bus[3:0], ecu[15:4], interval[31:16]
	input logic [1:0] s_axis_tuser, // req_type[1:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[2:0], frame_valid[3], frame_bus[6:4], frame_id[18:7],
	// pci_byte[26:19], service_byte[34:27], zero pad[39:35]
	output logic [39:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic [MASK_W-1:0] mask_q;
	logic [CNT_W-1:0] count_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0] req_q;
	logic [3:0] bus_q;
	logic [ID_W-1:0] ecu_q;
	logic [IVL_W-1:0] ivl_q;
	logic pre_bad_q;
	logic [ST_W-1:0] pre_st_q;
	logic dup_q;
	logic found_q;
	logic pend_vld_q;
	logic [BUS_W-1:0] pend_bus_q;
	logic [ID_W-1:0] pend_id_q;

	logic m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic m_tlast_q;

	entry_t cell_out [SLOTS];
	entry_t feed;
	entry_t head;
	entry_t nxt;
	logic shift;

	// ring: cell i loads from cell i+1, the tail loads the processed head, or its successor once a stop has matched
	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			entry_t cin;
			if (gi == SLOTS - 1) begin : g_tail
				assign cin = feed;
			end else begin : g_mid
				assign cin = cell_out[gi+1];
			end
			pks_cell u_cell (
				.clk (clk),
				.shift (shift),
				.din (cin),
				.dout (cell_out[gi])
			);
		end
	endgenerate

	assign head = cell_out[0];
	assign nxt = cell_out[NEXT_CELL];

	// input decode
	logic [1:0] in_req;
	logic [3:0] in_bus;
	logic [ID_W-1:0] in_ecu;
	logic [IVL_W-1:0] in_ivl;
	logic [3:0] in_bus_m1;
	logic bus_ok;
	logic ecu_ok;
	logic bus_inactive;
	logic in_bad;
	logic [ST_W-1:0] in_st;

	assign in_req = s_axis_tuser;
	assign in_bus = s_axis_tdata[3:0];
	assign in_ecu = s_axis_tdata[15:4];
	assign in_ivl = s_axis_tdata[31:16];
	assign in_bus_m1 = in_bus - 4'd1;
	assign bus_ok = (in_bus != 4'd0) && (in_bus <= 4'(BUS_COUNT));
	assign ecu_ok = (in_ecu != '0) && (in_ecu != ECU_LIMIT);
	assign bus_inactive = (in_bus > 4'd4) || !mask_q[in_bus_m1[1:0]];

	always_comb begin
		in_bad = 1'b0;
		in_st = ST_OK;
		if (in_req == REQ_START) begin
			if (!bus_ok || !ecu_ok || (in_ivl == '0)) begin
				in_bad = 1'b1;
				in_st = ST_BADARG;
			end else if (bus_inactive) begin
				in_bad = 1'b1;
				in_st = ST_INACTIVE;
			end
		end else if (in_req == REQ_STOP) begin
			if (!bus_ok || !ecu_ok) begin
				in_bad = 1'b1;
				in_st = ST_BADARG;
			end
		end
	end

	// head cell processing
	logic [3:0] key_bus_m1;
	logic act;
	logic key_hit;
	logic [IVL_W:0] phase_inc;
	logic fire;
	logic emit_run;
	logic out_free;
	logic adv;

	assign key_bus_m1 = bus_q - 4'd1;
	assign act = CNT_W'(step_q) < count_q;
	assign key_hit = act && (head.bus == key_bus_m1[BUS_W-1:0]) && (head.id == ecu_q);
	assign phase_inc = {1'b0, head.phase} + {{IVL_W{1'b0}}, 1'b1};
	assign fire = act && (phase_inc >= {1'b0, head.interval});
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign emit_run = (req_q == REQ_TICK) && fire && pend_vld_q;
	assign adv = !emit_run || out_free;
	assign shift = (state_q == ST_RUN) && adv;

	always_comb begin
		feed = head;
		case (req_q)
			REQ_TICK: begin
				if (act) begin
					feed.phase = fire ? '0 : phase_inc[IVL_W-1:0];
				end
			end
			REQ_START: begin
				if ((CNT_W'(step_q) == count_q) && !dup_q) begin
					feed.bus = key_bus_m1[BUS_W-1:0];
					feed.id = ecu_q;
					feed.interval = ivl_q;
					feed.phase = '0;
				end
			end
			REQ_STOP: begin
				// once the match has passed, each slot takes its successor
				if (key_hit || found_q) begin
					feed = nxt;
				end
			end
			default: begin
				feed = head;
			end
		endcase
	end

	// final result of an item
	logic [ST_W-1:0] fin_st;
	logic fin_frame;
	logic [CNT_W-1:0] fin_count;

	always_comb begin
		fin_st = ST_OK;
		fin_frame = 1'b0;
		fin_count = count_q;
		if (pre_bad_q) begin
			fin_st = pre_st_q;
		end else begin
			case (req_q)
				REQ_TICK: begin
					fin_frame = pend_vld_q;
				end
				REQ_START: begin
					if (dup_q) begin
						fin_st = ST_DUP;
					end else if (count_q == CNT_W'(SLOTS)) begin
						fin_st = ST_FULL;
					end else begin
						fin_count = count_q + CNT_W'(1);
					end
				end
				REQ_STOP: begin
					if (found_q) begin
						fin_count = count_q - CNT_W'(1);
					end else begin
						fin_st = ST_NOTFOUND;
					end
				end
				REQ_STOP_ALL: begin
					if (count_q == '0) begin
						fin_st = ST_EMPTY;
					end else begin
						fin_count = '0;
					end
				end
				default: begin
					fin_st = ST_OK;
				end
			endcase
		end
	end

	// result mux toward the output register
	logic emit;
	logic [ST_W-1:0] res_st;
	logic res_frame;
	logic res_last;
	logic [FBUS_W-1:0] res_bus;
	logic [39:0] res_data;

	always_comb begin
		emit = 1'b0;
		res_st = ST_OK;
		res_frame = 1'b0;
		res_last = 1'b0;
		if (state_q == ST_RUN) begin
			emit = emit_run;
			res_frame = 1'b1;
		end else if (state_q == ST_FIN) begin
			emit = 1'b1;
			res_st = fin_st;
			res_frame = fin_frame;
			res_last = 1'b1;
		end
		res_bus = res_frame ? (FBUS_W'(pend_bus_q) + FBUS_W'(1)) : '0;
		res_data = {5'd0,
			res_frame ? SVC_TESTER_PRESENT : 8'd0,
			res_frame ? PCI_SINGLE_LEN2 : 8'd0,
			res_frame ? pend_id_q : {ID_W{1'b0}},
			res_bus,
			res_frame,
			res_st};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			step_q <= '0;
			pre_bad_q <= 1'b0;
			dup_q <= 1'b0;
			found_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						pre_bad_q <= in_bad;
						dup_q <= 1'b0;
						found_q <= 1'b0;
						pend_vld_q <= 1'b0;
						step_q <= '0;
						if (in_bad || (in_req == REQ_STOP_ALL)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (adv) begin
						dup_q <= dup_q | key_hit;
						found_q <= found_q | key_hit;
						if ((req_q == REQ_TICK) && fire) begin
							pend_vld_q <= 1'b1;
						end
						if (step_q == STEP_W'(SLOTS - 1)) begin
							step_q <= '0;
							state_q <= ST_FIN;
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						count_q <= fin_count;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request arguments and the frame waiting for its last flag
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			req_q <= in_req;
			bus_q <= in_bus;
			ecu_q <= in_ecu;
			ivl_q <= in_ivl;
			pre_st_q <= in_st;
		end
		if (shift && (req_q == REQ_TICK) && fire) begin
			pend_bus_q <= head.bus;
			pend_id_q <= head.id;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			m_tdata_q <= res_data;
			m_tlast_q <= res_last;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;
	assign m_axis_tlast = m_tlast_q;

	`PKS_ASSERT(a_count_range, count_q <= CNT_W'(SLOTS), "entry count above slot count")
	`PKS_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready,
		state_q != ST_IDLE, "sequencer stayed idle after an accepted transaction")
	`PKS_ASSERT_NEXT(a_fin_returns, state_q == ST_FIN && out_free,
		state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast,
		"final result not issued with last")
	`PKS_ASSERT(a_frame_ok_status, !(m_axis_tvalid && m_axis_tdata[3]) || m_axis_tdata[2:0] == ST_OK,
		"frame result carries a non-ok status")
	`PKS_ASSERT(a_run_starts_at_head,
		!(state_q == ST_RUN && $past(state_q) == ST_IDLE) || step_q == '0,
		"ring walk did not start at the head slot")

endmodule
